[hw/rtl/irq_aff_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package irq_aff_pkg;

   localparam int NUM_CPUS    = 4;
   localparam int NUM_LINES   = 64;
   localparam int CASCADE_BIT = 55;

   // CPU and line numbering follow the 2-bit cpu field and the 64-bit words
   localparam int CPU_SLOTS = 4;
   localparam int WORD_W    = 64;
   localparam int GROUP_W   = 8;
   localparam int GROUPS    = (NUM_LINES + GROUP_W - 1) / GROUP_W;
   localparam int GSEL_W    = 3;
   localparam int LINE_W    = 6;
   localparam int VEC_W     = 12;

   localparam logic [VEC_W-1:0]  VEC_BASE   = 12'h900;
   localparam logic [WORD_W-1:0] CASC_MASK  = 64'd1 << CASCADE_BIT;
   localparam logic [WORD_W-1:0] LINE_MASK  =
      (NUM_LINES >= WORD_W) ? {WORD_W{1'b1}} : ((64'd1 << (NUM_LINES % WORD_W)) - 64'd1);
   localparam logic [GSEL_W-1:0] TOP_GROUP  = GSEL_W'(GROUPS - 1);

   localparam logic REG_BOOT_CPU     = 1'b0;
   localparam logic REG_CPUS_PRESENT = 1'b1;

   typedef enum logic [1:0] {
      ACT_ENABLE   = 2'd0,
      ACT_DISABLE  = 2'd1,
      ACT_AFFINITY = 2'd2,
      ACT_DISPATCH = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPLY,
      ST_ROUTE,
      ST_EMIT,
      ST_MASK,
      ST_SCAN
   } state_type;

   // result of one step of the highest-bit search
   typedef struct packed {
      logic              hit;
      logic [LINE_W-1:0] line;
      logic              last;
   } pick_type;

endpackage

`default_nettype wire

[hw/rtl/irq_aff_pick.sv]
`timescale 1ns / 1ps
`default_nettype none

// Looks at one byte group of the remaining set, finds its highest bit and
// returns the set with that bit cleared.
module irq_aff_pick (
   input  wire logic [irq_aff_pkg::WORD_W-1:0] remaining,
   input  wire logic [irq_aff_pkg::GSEL_W-1:0] group_sel,
   output irq_aff_pkg::pick_type               pick,
   output      logic [irq_aff_pkg::WORD_W-1:0] rest
);
   import irq_aff_pkg::*;

   logic [GROUP_W-1:0] grp_bits;
   logic [2:0]         idx;
   logic [LINE_W-1:0]  line;

   assign grp_bits = remaining[{group_sel, 3'b000} +: GROUP_W];

   always_comb begin
      idx = 3'd0;
      for (int i = 0; i < GROUP_W; i++) begin
         if (grp_bits[i]) begin
            idx = 3'(i);
         end
      end
   end

   assign line      = {group_sel, idx};
   assign rest      = remaining & ~(64'd1 << line);
   assign pick.hit  = |grp_bits;
   assign pick.line = line;
   assign pick.last = (rest == '0);

endmodule

`default_nettype wire

[hw/rtl/irq_affinity_router_dispatcher.sv]
// Interrupt router with per-CPU affinity and a vector dispatcher.
// Request channel (req_*): valid/ready. action selects enable line, disable
// line, set affinity (cpu_set) or dispatch (pending bits taken by cpu_id).
// Response channel (rsp_*): valid/ready. Updates give one item with the four
// routed mask words (result_kind 0); a dispatch gives one item per pending
// line that the CPU's affinity allows, vector 0x900 + 16*line, highest line
// first, last set on the final one, and nothing if no line qualifies.
// Config (csr_*): APB-style, boot_cpu at 0x0, cpus_present at 0x4, write only
// while the block is idle; pready is tied high.
// Sequence: one item at a time. An update applies the change, passes each CPU
// in turn through the shared route unit, then loads the response. A dispatch
// first masks the pending set, then the byte-group search unit steps down
// past empty groups and emits one vector per set bit it finds; an empty set
// ends the search with no response.
// The response sits in an output register, so a new item can be accepted
// while the last response of the previous one is still waiting. When the
// receiver stalls, a pending result holds and the sequencer waits.
// Reset: enables clear, affinities go to all ones, boot_cpu 0, cpus_present 1.
`timescale 1ns / 1ps
`default_nettype none

module irq_affinity_router_dispatcher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [1:0]  req_action,
   input  wire logic [5:0]  req_irq_line,
   input  wire logic [3:0]  req_cpu_set,
   input  wire logic [63:0] req_pending,
   input  wire logic [1:0]  req_cpu_id,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic        rsp_result_kind,
   output      logic [63:0] rsp_dim_cpu0,
   output      logic [63:0] rsp_dim_cpu1,
   output      logic [63:0] rsp_dim_cpu2,
   output      logic [63:0] rsp_dim_cpu3,
   output      logic [11:0] rsp_vector,
   output      logic        rsp_last,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);
   import irq_aff_pkg::*;

   state_type         state_ff, state_in;
   action_type        action_ff, action_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [3:0]        cset_ff, cset_in;
   logic [WORD_W-1:0] pend_ff, pend_in;
   logic [1:0]        cpu_ff, cpu_in;
   logic [GSEL_W-1:0] group_ff, group_in;

   logic [1:0]        boot_cpu_ff, boot_cpu_in;
   logic [3:0]        present_ff, present_in;
   logic [WORD_W-1:0] enable_ff, enable_in;
   logic [WORD_W-1:0] aff_ff [CPU_SLOTS];
   logic [WORD_W-1:0] aff_in [CPU_SLOTS];
   logic [WORD_W-1:0] remaining_ff, remaining_in;
   logic [WORD_W-1:0] word_ff [CPU_SLOTS];
   logic [WORD_W-1:0] word_in [CPU_SLOTS];

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [WORD_W-1:0] rsp_dim_ff [CPU_SLOTS];
   logic [WORD_W-1:0] rsp_dim_in [CPU_SLOTS];
   logic [VEC_W-1:0]  rsp_vector_ff, rsp_vector_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              req_fire;
   logic              out_free;
   logic              rem_zero;
   logic              csr_write;
   logic              load_mask_rsp;
   logic              load_vec_rsp;
   logic [WORD_W-1:0] line_bit;
   logic [WORD_W-1:0] aff_rd;
   logic [WORD_W-1:0] route_word;
   pick_type          pick;
   logic [WORD_W-1:0] pick_rest;

   irq_aff_pick u_pick (
      .remaining (remaining_ff),
      .group_sel (group_ff),
      .pick      (pick),
      .rest      (pick_rest)
   );

   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rem_zero  = (remaining_ff == '0);
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign line_bit  = (32'(line_ff) < NUM_LINES) ? (64'd1 << line_ff) : '0;
   assign aff_rd    = aff_ff[cpu_ff];

   // shared route unit: one CPU word per cycle
   always_comb begin
      route_word = '0;
      if (32'(cpu_ff) < NUM_CPUS && present_ff[cpu_ff]) begin
         route_word = enable_ff & ~CASC_MASK & aff_rd;
         if (cpu_ff == boot_cpu_ff) begin
            route_word = route_word | CASC_MASK;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (action_type'(req_action) == ACT_DISPATCH) ? ST_MASK : ST_APPLY;
            end
         end
         ST_APPLY: state_in = ST_ROUTE;
         ST_ROUTE: begin
            if (32'(cpu_ff) == CPU_SLOTS - 1) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_MASK: state_in = ST_SCAN;
         ST_SCAN: begin
            if (rem_zero || (pick.hit && out_free && pick.last)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready     = 1'b0;
      load_mask_rsp = 1'b0;
      load_vec_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready     = 1'b1;
         ST_EMIT:  load_mask_rsp = out_free;
         ST_SCAN:  load_vec_rsp  = !rem_zero && pick.hit && out_free;
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      action_in    = action_ff;
      line_in      = line_ff;
      cset_in      = cset_ff;
      pend_in      = pend_ff;
      cpu_in       = cpu_ff;
      group_in     = group_ff;
      enable_in    = enable_ff;
      remaining_in = remaining_ff;
      aff_in       = aff_ff;
      word_in      = word_ff;
      boot_cpu_in  = boot_cpu_ff;
      present_in   = present_ff;

      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_BOOT_CPU:     boot_cpu_in = csr_pwdata[1:0];
            REG_CPUS_PRESENT: present_in  = csr_pwdata[3:0];
            default: begin
            end
         endcase
      end

      if (req_fire) begin
         action_in = action_type'(req_action);
         line_in   = req_irq_line;
         cset_in   = req_cpu_set;
         pend_in   = req_pending;
         cpu_in    = (action_type'(req_action) == ACT_DISPATCH) ? req_cpu_id : 2'd0;
      end

      unique case (state_ff)
         ST_APPLY: begin
            unique case (action_ff)
               ACT_ENABLE:  enable_in = enable_ff | line_bit;
               ACT_DISABLE: enable_in = enable_ff & ~line_bit;
               ACT_AFFINITY: begin
                  for (int c = 0; c < CPU_SLOTS; c++) begin
                     if (c < NUM_CPUS) begin
                        aff_in[c] = cset_ff[c] ? (aff_ff[c] | line_bit)
                                               : (aff_ff[c] & ~line_bit);
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         ST_ROUTE: begin
            word_in[cpu_ff] = route_word;
            cpu_in          = cpu_ff + 2'd1;
         end
         ST_MASK: begin
            remaining_in = (32'(cpu_ff) < NUM_CPUS) ? (pend_ff & LINE_MASK & aff_rd) : '0;
            group_in     = TOP_GROUP;
         end
         ST_SCAN: begin
            if (!rem_zero) begin
               if (!pick.hit) begin
                  group_in = group_ff - 3'd1;
               end else if (out_free) begin
                  remaining_in = pick_rest;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_dim_in    = rsp_dim_ff;
      rsp_vector_in = rsp_vector_ff;
      rsp_last_in   = rsp_last_ff;
      if (load_mask_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = 1'b0;
         rsp_dim_in    = word_ff;
         rsp_vector_in = '0;
         rsp_last_in   = 1'b1;
      end else if (load_vec_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = 1'b1;
         for (int c = 0; c < CPU_SLOTS; c++) begin
            rsp_dim_in[c] = '0;
         end
         rsp_vector_in = VEC_BASE + {2'b00, pick.line, 4'b0000};
         rsp_last_in   = pick.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         boot_cpu_ff  <= 2'd0;
         present_ff   <= 4'd1;
         enable_ff    <= '0;
         remaining_ff <= '0;
         for (int c = 0; c < CPU_SLOTS; c++) begin
            aff_ff[c] <= '1;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         boot_cpu_ff  <= boot_cpu_in;
         present_ff   <= present_in;
         enable_ff    <= enable_in;
         remaining_ff <= remaining_in;
         aff_ff       <= aff_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      line_ff       <= line_in;
      cset_ff       <= cset_in;
      pend_ff       <= pend_in;
      cpu_ff        <= cpu_in;
      group_ff      <= group_in;
      word_ff       <= word_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_dim_ff    <= rsp_dim_in;
      rsp_vector_ff <= rsp_vector_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_dim_cpu0    = rsp_dim_ff[0];
   assign rsp_dim_cpu1    = rsp_dim_ff[1];
   assign rsp_dim_cpu2    = rsp_dim_ff[2];
   assign rsp_dim_cpu3    = rsp_dim_ff[3];
   assign rsp_vector      = rsp_vector_ff;
   assign rsp_last        = rsp_last_ff;

   assign csr_pready = 1'b1;
   always_comb begin
      unique case (csr_paddr[2])
         REG_BOOT_CPU:     csr_prdata = {30'd0, boot_cpu_ff};
         REG_CPUS_PRESENT: csr_prdata = {28'd0, present_ff};
         default:          csr_prdata = '0;
      endcase
   end

`ifndef SYNTHESIS
   a_vec_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind |->
         rsp_vector[3:0] == 4'd0 && rsp_vector >= VEC_BASE &&
         rsp_dim_cpu0 == '0 && rsp_dim_cpu3 == '0)
      else $error("vector item malformed");

   a_mask_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_kind |-> rsp_last && rsp_vector == '0)
      else $error("mask item not last or carries a vector");

   a_absent_cpu0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_kind && !present_ff[0] |-> rsp_dim_cpu0 == '0)
      else $error("absent CPU 0 has a routed word");

   a_scan_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && rem_zero |=> state_ff == ST_IDLE)
      else $error("dispatch did not finish on empty set");
`endif

endmodule

`default_nettype wire
